// ----- src/dswd_pkg.sv -----
// ----------------------------------------------------------------------------
// dswd_pkg: shared definitions for the damage spike window detector
// Widths, register reset values, sequencer states and the control and status
// bundles passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package dswd_pkg;

    localparam int DATA_W           = 32;
    localparam int PCT_W            = 7;
    localparam int WIN_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int PROD_W           = DATA_W + PCT_W;
    localparam int HISTORY_DEPTH_DEF = 8;

    localparam logic [PCT_W-1:0] SPIKE_PCT_RST = 7'd5;
    localparam logic [PCT_W-1:0] CUM_PCT_RST   = 7'd12;
    localparam logic [PCT_W-1:0] SEV_PCT_RST   = 7'd20;
    localparam logic [WIN_W-1:0] WINDOW_RST    = 16'd3000;
    localparam logic [PCT_W-1:0] PCT_SCALE     = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPIKE_PCT = 2'd0,
        CFG_CUM_PCT   = 2'd1,
        CFG_SEV_PCT   = 2'd2,
        CFG_WINDOW_MS = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_SPIKE = 2'd1,
        CAUSE_CUM   = 2'd2,
        CAUSE_SEV   = 2'd3
    } t_cause;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RECORD,
        ST_MUL_REF,
        ST_MUL_AMT,
        ST_COMPARE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic   accept;
        logic   early;
        logic   near;
        logic   ge;
        logic   scan_last;
        t_cause test;
        logic   out_free;
    } t_status;

    typedef struct packed {
        logic in_ready;
        logic decide;
        logic record;
        logic mul_ref;
        logic mul_amt;
        logic compare;
        logic scan;
        logic done;
    } t_ctrl;

endpackage

// ----- src/damage_spike_window_detector.sv -----
// ----------------------------------------------------------------------------
// damage_spike_window_detector: level drop spike and window loss detector
// Tracks the last level sample and a ring of recent drops, and flags a
// single-sample spike, a windowed cumulative loss or a severe windowed loss.
// ----------------------------------------------------------------------------
// Each request takes one result transfer. The block handles one request at a
// time: it is ready only when idle. A clear request, a dead sample, a seeding
// sample or a zero maximum go from the decide step straight to the result
// load. A full sample passes through decide and record, the percent tests
// (one shared 32x7 multiplier forms the reference product and then the scaled
// amount, and a compare follows) and the ring scan, then the result load. The
// ring scan reads one ring slot per cycle from the drop memories and
// accumulates through a single saturating adder. A stalled result holds the
// block until the output register frees.
// The result sits in an output register, so the next request is accepted as
// soon as the result is loaded.
// There is no clearing pass after reset: each ring slot carries a valid bit.
// ----------------------------------------------------------------------------
module damage_spike_window_detector #(
    parameter int HISTORY_DEPTH = dswd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_req_type,
    input  logic [dswd_pkg::DATA_W-1:0]     i_now_ms,
    input  logic [dswd_pkg::DATA_W-1:0]     i_level_now,
    input  logic [dswd_pkg::DATA_W-1:0]     i_level_max,
    input  logic                            i_is_alive,
    input  logic                            i_attacker_near,
    // Result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_trip,
    output logic [1:0]                      o_trip_cause,
    output logic [dswd_pkg::DATA_W-1:0]     o_window_loss,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [dswd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dswd_pkg::WIN_W-1:0]      i_cfg_data
);

    localparam int IDXW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW   = $clog2(HISTORY_DEPTH + 2);
    localparam int DW   = dswd_pkg::DATA_W;

    // Configuration registers.
    logic [dswd_pkg::PCT_W-1:0] r_spike_pct;
    logic [dswd_pkg::PCT_W-1:0] r_cum_pct;
    logic [dswd_pkg::PCT_W-1:0] r_sev_pct;
    logic [dswd_pkg::WIN_W-1:0] r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spike_pct <= dswd_pkg::SPIKE_PCT_RST;
            r_cum_pct   <= dswd_pkg::CUM_PCT_RST;
            r_sev_pct   <= dswd_pkg::SEV_PCT_RST;
            r_window    <= dswd_pkg::WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (dswd_pkg::t_cfg_idx'(i_cfg_idx))
                dswd_pkg::CFG_SPIKE_PCT: r_spike_pct <= i_cfg_data[dswd_pkg::PCT_W-1:0];
                dswd_pkg::CFG_CUM_PCT:   r_cum_pct   <= i_cfg_data[dswd_pkg::PCT_W-1:0];
                dswd_pkg::CFG_SEV_PCT:   r_sev_pct   <= i_cfg_data[dswd_pkg::PCT_W-1:0];
                dswd_pkg::CFG_WINDOW_MS: r_window    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    dswd_pkg::t_ctrl   ctrl;
    dswd_pkg::t_status status;

    dswd_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // Captured request.
    logic          r_req;
    logic [DW-1:0] r_now;
    logic [DW-1:0] r_lvl;
    logic [DW-1:0] r_max;
    logic          r_alive;
    logic          r_near;

    logic accept;
    assign accept  = i_valid && ctrl.in_ready;
    assign o_ready = ctrl.in_ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req_type;
            r_now   <= i_now_ms;
            r_lvl   <= i_level_now;
            r_max   <= i_level_max;
            r_alive <= i_is_alive;
            r_near  <= i_attacker_near;
        end
    end

    // Level tracking and drop computation. A last level of zero means the
    // block is unseeded, so the sample only seeds it.
    logic [DW-1:0] r_last;
    logic [DW-1:0] r_drop;
    logic          early;

    assign early = r_req || !r_alive || (r_last == '0) || (r_max == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (ctrl.decide && !r_req && r_alive) begin
            r_last <= r_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.decide) begin
            r_drop <= (r_lvl < r_last) ? (r_last - r_lvl) : '0;
        end
    end

    // Drop ring: valid bits in flops, time and amount in memories.
    logic [HISTORY_DEPTH-1:0] r_valid;
    logic [IDXW-1:0]          r_slot;
    logic                     ring_we;
    logic [IDXW-1:0]          ring_raddr;
    logic [DW-1:0]            rd_time;
    logic [DW-1:0]            rd_amt;

    assign ring_we = ctrl.record && (r_drop != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_slot  <= '0;
        end else if (ctrl.decide && r_req) begin
            r_valid <= '0;
            r_slot  <= '0;
        end else if (ring_we) begin
            r_valid[r_slot] <= 1'b1;
            r_slot <= (r_slot == IDXW'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        end
    end

    dswd_ram #(
        .WIDTH (DW),
        .DEPTH (HISTORY_DEPTH)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata (r_now),
        .i_raddr (ring_raddr),
        .o_rdata (rd_time)
    );

    dswd_ram #(
        .WIDTH (DW),
        .DEPTH (HISTORY_DEPTH)
    ) u_amt_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata (r_drop),
        .i_raddr (ring_raddr),
        .o_rdata (rd_amt)
    );

    // Ring scan: address issue, memory read, age check, then accumulate.
    logic [CW-1:0]   r_cnt;
    logic            issue;
    logic            r_s1_vld;
    logic [IDXW-1:0] r_s1_idx;
    logic            r_s2_hit;
    logic [DW-1:0]   r_s2_amt;
    logic [DW-1:0]   r_sum;
    logic            r_loss_en;
    logic [DW:0]     sum_ext;
    logic [DW-1:0]   age;
    logic            scan_last;

    assign issue      = ctrl.scan && (r_cnt < CW'(HISTORY_DEPTH));
    assign ring_raddr = r_cnt[IDXW-1:0];
    assign scan_last  = ctrl.scan && (r_cnt == CW'(HISTORY_DEPTH + 1));
    assign age        = r_now - rd_time;
    assign sum_ext    = {1'b0, r_sum} + {1'b0, r_s2_amt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_s1_vld <= 1'b0;
            r_s2_hit <= 1'b0;
        end else begin
            if (ctrl.record) begin
                r_cnt <= '0;
            end else if (ctrl.scan) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_s1_vld <= issue;
            r_s2_hit <= r_s1_vld && r_valid[r_s1_idx]
                        && (age <= DW'(r_window));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= ring_raddr;
        r_s2_amt <= rd_amt;
    end

    // The window sum saturates at all ones.
    always_ff @(posedge i_clk) begin
        if (ctrl.decide) begin
            r_sum     <= '0;
            r_loss_en <= 1'b0;
        end else begin
            if (ctrl.scan && r_s2_hit) begin
                r_sum <= sum_ext[DW] ? '1 : sum_ext[DW-1:0];
            end
            if (scan_last) begin
                r_loss_en <= 1'b1;
            end
        end
    end

    // Percent tests: 100 * amount >= pct * max, both products from one
    // shared multiplier. The reference product is held while the scaled
    // amount is formed.
    dswd_pkg::t_cause           r_test;
    logic [dswd_pkg::PCT_W-1:0] mul_b;
    logic [DW-1:0]              mul_a;
    logic [dswd_pkg::PROD_W-1:0] prod;
    logic [dswd_pkg::PROD_W-1:0] r_ref;
    logic                       ge;

    always_comb begin
        mul_a = r_max;
        mul_b = dswd_pkg::PCT_SCALE;
        if (ctrl.mul_amt) begin
            mul_a = (r_test == dswd_pkg::CAUSE_SPIKE) ? r_drop : r_sum;
        end else begin
            case (r_test)
                dswd_pkg::CAUSE_SPIKE: mul_b = r_spike_pct;
                dswd_pkg::CAUSE_CUM:   mul_b = r_cum_pct;
                default:               mul_b = r_sev_pct;
            endcase
        end
    end

    dswd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign ge = prod >= r_ref;

    always_ff @(posedge i_clk) begin
        if (ctrl.mul_amt) begin
            r_ref <= prod;
        end
    end

    // Test selection and trip outcome.
    logic             r_trip;
    dswd_pkg::t_cause r_cause;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test  <= dswd_pkg::CAUSE_SPIKE;
            r_trip  <= 1'b0;
            r_cause <= dswd_pkg::CAUSE_NONE;
        end else begin
            if (ctrl.decide) begin
                r_trip  <= 1'b0;
                r_cause <= dswd_pkg::CAUSE_NONE;
            end else if (ctrl.compare && ge) begin
                r_trip  <= 1'b1;
                r_cause <= r_test;
            end
            if (ctrl.record) begin
                r_test <= dswd_pkg::CAUSE_SPIKE;
            end else if (scan_last) begin
                r_test <= r_near ? dswd_pkg::CAUSE_SEV : dswd_pkg::CAUSE_CUM;
            end else if (ctrl.compare && !ge && (r_test == dswd_pkg::CAUSE_CUM)) begin
                r_test <= dswd_pkg::CAUSE_SEV;
            end
        end
    end

    // Output register.
    logic          r_ovld;
    logic          r_otrip;
    logic [1:0]    r_ocause;
    logic [DW-1:0] r_oloss;
    logic          out_free;

    assign out_free = !r_ovld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (ctrl.done && out_free) begin
            r_ovld <= 1'b1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.done && out_free) begin
            r_otrip  <= r_trip;
            r_ocause <= r_cause;
            r_oloss  <= r_loss_en ? r_sum : '0;
        end
    end

    assign o_valid       = r_ovld;
    assign o_trip        = r_otrip;
    assign o_trip_cause  = r_ocause;
    assign o_window_loss = r_oloss;

    // Status back to the sequencer.
    always_comb begin
        status           = '0;
        status.accept    = accept;
        status.early     = early;
        status.near      = r_near;
        status.ge        = ge;
        status.scan_last = scan_last;
        status.test      = r_test;
        status.out_free  = out_free;
    end

`ifndef SYNTHESIS
    // A transfer in leaves the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("block still ready after an input transfer");

    // A trip always carries a cause, and no trip carries none.
    a_trip_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_trip == (o_trip_cause != 2'(dswd_pkg::CAUSE_NONE))))
        else $error("trip flag and cause disagree");

    // A spike trip is decided before the window sum is formed.
    a_spike_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_trip_cause == 2'(dswd_pkg::CAUSE_SPIKE))) |-> (o_window_loss == '0))
        else $error("spike trip reported a window loss");

    // The ring write pointer stays inside the ring.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slot) < HISTORY_DEPTH)
        else $error("ring write slot out of range");
`endif

endmodule

// ----- src/dswd_ram.sv -----
// ----------------------------------------------------------------------------
// dswd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dswd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/dswd_mul.sv -----
// ----------------------------------------------------------------------------
// dswd_mul: shared percent multiplier
// Multiplies a 32-bit operand by a 7-bit factor with a registered product.
// ----------------------------------------------------------------------------
module dswd_mul (
    input  logic                         i_clk,
    input  logic [dswd_pkg::DATA_W-1:0]  i_a,
    input  logic [dswd_pkg::PCT_W-1:0]   i_b,
    output logic [dswd_pkg::PROD_W-1:0]  o_p
);

    logic [dswd_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= dswd_pkg::PROD_W'(i_a) * dswd_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- src/dswd_fsm.sv -----
// ----------------------------------------------------------------------------
// dswd_fsm: sequencer of the damage spike window detector
// Steps one request through decision, recording, the ring scan and the
// percent tests, and drives the datapath enables.
// ----------------------------------------------------------------------------
module dswd_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dswd_pkg::t_status i_status,
    output dswd_pkg::t_ctrl   o_ctrl
);

    dswd_pkg::t_state r_state;
    dswd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dswd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dswd_pkg::ST_IDLE: begin
                if (i_status.accept) n_state = dswd_pkg::ST_DECIDE;
            end
            dswd_pkg::ST_DECIDE: begin
                n_state = i_status.early ? dswd_pkg::ST_DONE : dswd_pkg::ST_RECORD;
            end
            dswd_pkg::ST_RECORD: begin
                n_state = i_status.near ? dswd_pkg::ST_SCAN : dswd_pkg::ST_MUL_REF;
            end
            dswd_pkg::ST_MUL_REF: begin
                n_state = dswd_pkg::ST_MUL_AMT;
            end
            dswd_pkg::ST_MUL_AMT: begin
                n_state = dswd_pkg::ST_COMPARE;
            end
            dswd_pkg::ST_COMPARE: begin
                if (i_status.ge) begin
                    n_state = dswd_pkg::ST_DONE;
                end else if (i_status.test == dswd_pkg::CAUSE_SPIKE) begin
                    n_state = dswd_pkg::ST_SCAN;
                end else if (i_status.test == dswd_pkg::CAUSE_CUM) begin
                    n_state = dswd_pkg::ST_MUL_REF;
                end else begin
                    n_state = dswd_pkg::ST_DONE;
                end
            end
            dswd_pkg::ST_SCAN: begin
                if (i_status.scan_last) n_state = dswd_pkg::ST_MUL_REF;
            end
            dswd_pkg::ST_DONE: begin
                if (i_status.out_free) n_state = dswd_pkg::ST_IDLE;
            end
            default: n_state = dswd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            dswd_pkg::ST_IDLE:    o_ctrl.in_ready = 1'b1;
            dswd_pkg::ST_DECIDE:  o_ctrl.decide   = 1'b1;
            dswd_pkg::ST_RECORD:  o_ctrl.record   = 1'b1;
            dswd_pkg::ST_MUL_REF: o_ctrl.mul_ref  = 1'b1;
            dswd_pkg::ST_MUL_AMT: o_ctrl.mul_amt  = 1'b1;
            dswd_pkg::ST_COMPARE: o_ctrl.compare  = 1'b1;
            dswd_pkg::ST_SCAN:    o_ctrl.scan     = 1'b1;
            dswd_pkg::ST_DONE:    o_ctrl.done     = 1'b1;
            default:              o_ctrl = '0;
        endcase
    end

endmodule
